// ----- src/cfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfp_pkg: shared definitions for the cursor framebuffer peripheral
// Holds the bus address map, the beat widths of both stream channels and the
// result record used by the core.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // Register map of the peripheral (full 32-bit bus addresses).
  localparam logic [31:0] ADDR_ROW     = 32'h4001_0000;
  localparam logic [31:0] ADDR_COLUMN  = 32'h4001_0004;
  localparam logic [31:0] ADDR_COLOR   = 32'h4001_0008;
  localparam logic [31:0] ADDR_REFRESH = 32'h4001_000C;
  localparam logic [31:0] ADDR_CLEAR   = 32'h4001_0010;
  localparam logic [31:0] ADDR_KEYS    = 32'h4001_0020;

  // Bus access kinds carried in the input tuser bit.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam int WORD_W      = 32;
  localparam int PIXEL_W     = 32;
  localparam int IN_TDATA_W  = 96;  // addr, wdata, keys
  localparam int IN_TUSER_W  = 1;   // cmd
  localparam int OUT_TDATA_W = 40;  // rdata, status, refresh_request, padding

  // One result beat before packing.
  typedef struct packed {
    logic              refresh_request;
    logic              status;
    logic [WORD_W-1:0] rdata;
  } result_t;

endpackage

// ----- src/cfp_ram.sv -----
// ----------------------------------------------------------------------------
// cfp_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module cfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/cursor_framebuffer_peripheral_core.sv -----
// ----------------------------------------------------------------------------
// cursor_framebuffer_peripheral_core: framebuffer with row/column cursor
// Memory-mapped pixel store addressed through cursor registers, with a key
// word read-back and refresh requests.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat is one bus access: in_tuser[0] is the access kind (0 read,
// 1 write), in_tdata carries addr [31:0], wdata [63:32] and keys [95:64].
// Each accepted beat gives exactly one output beat carrying rdata [31:0],
// status [32] and refresh_request [33].
// The result appears in the output register in the cycle after acceptance, and
// a new access can be accepted every cycle unless a sweep or a stall holds it. A
// pixel read takes its data straight from the pixel RAM's registered read port.
// The pixel store is cleared by a sweep that writes one entry per cycle,
// covering all SCREEN_COLUMNS * SCREEN_ROWS entries (76800 by default). The sweep runs
// after reset and after every accepted clear write; in_tready is low
// throughout. The clear write's own result is delivered without waiting.
// When the receiver stalls, the pending output beat is held and in_tready
// drops until it is taken.
// Reset zeroes both cursors, empties the output register and starts the sweep.
// ----------------------------------------------------------------------------
module cursor_framebuffer_peripheral_core #(
  parameter int SCREEN_COLUMNS = 320,
  parameter int SCREEN_ROWS    = 240
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cfp_pkg::IN_TDATA_W-1:0]   in_tdata,   // addr[31:0], wdata[63:32], keys[95:64]
  input  logic [cfp_pkg::IN_TUSER_W-1:0]   in_tuser,   // cmd[0]
  // Result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cfp_pkg::OUT_TDATA_W-1:0]  out_tdata   // rdata[31:0], status[32], refresh_request[33]
);

  import cfp_pkg::*;

  localparam int PIXEL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int IDX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int ROW_W = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int COL_W = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    sweep_r, sweep_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                out_v_r, out_v_nxt;
  logic                out_pix_r, out_pix_nxt;
  result_t             res_r, res_nxt;

  logic                in_acc;
  logic                cmd;
  logic [WORD_W-1:0]   addr;
  logic [WORD_W-1:0]   wdata;
  logic [WORD_W-1:0]   keys;
  logic                cursor_upd;
  logic [ROW_W-1:0]    mul_row;
  logic [COL_W-1:0]    mul_col;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [PIXEL_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [PIXEL_W-1:0]  ram_rdata;

  assign cmd   = in_tuser[0];
  assign addr  = in_tdata[WORD_W-1:0];
  assign wdata = in_tdata[2*WORD_W-1:WORD_W];
  assign keys  = in_tdata[3*WORD_W-1:2*WORD_W];

  // Accept only outside the sweep and when the output register can move on.
  assign in_tready = (state_r == ST_RUN) && (!out_v_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // Decode of one access and next-state logic.
  always_comb begin
    state_nxt   = state_r;
    sweep_nxt   = sweep_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    out_pix_nxt = out_pix_r;
    res_nxt     = res_r;
    cursor_upd  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = wdata;
    ram_re      = 1'b0;
    out_v_nxt   = out_v_r && !out_tready;

    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = '0;
      sweep_nxt = sweep_r + 1'b1;
      if (sweep_r == LAST_IDX) begin
        state_nxt = ST_RUN;
        sweep_nxt = '0;
      end
    end

    if (in_acc) begin
      out_v_nxt               = 1'b1;
      out_pix_nxt             = 1'b0;
      res_nxt.rdata           = '0;
      res_nxt.status          = STATUS_OK;
      res_nxt.refresh_request = 1'b0;
      if (cmd == CMD_WRITE) begin
        case (addr)
          ADDR_ROW: begin
            if (wdata < WORD_W'(SCREEN_ROWS)) begin
              row_nxt    = wdata[ROW_W-1:0];
              cursor_upd = 1'b1;
            end else begin
              res_nxt.status = STATUS_ERR;
            end
          end
          ADDR_COLUMN: begin
            if (wdata < WORD_W'(SCREEN_COLUMNS)) begin
              col_nxt    = wdata[COL_W-1:0];
              cursor_upd = 1'b1;
            end else begin
              res_nxt.status = STATUS_ERR;
            end
          end
          ADDR_COLOR: begin
            ram_we = 1'b1;
          end
          ADDR_REFRESH: begin
            res_nxt.refresh_request = 1'b1;
          end
          ADDR_CLEAR: begin
            res_nxt.refresh_request = 1'b1;
            state_nxt               = ST_CLEAR;
            sweep_nxt               = '0;
          end
          default: begin
            res_nxt.status = STATUS_ERR;
          end
        endcase
      end else begin
        case (addr)
          ADDR_REFRESH: begin
            ram_re      = 1'b1;
            out_pix_nxt = 1'b1;
          end
          ADDR_KEYS: begin
            res_nxt.rdata = keys;
          end
          default: begin
            res_nxt.status = STATUS_ERR;
          end
        endcase
      end
    end
  end

  // Linear pixel index, recomputed whenever a cursor register changes.
  assign mul_row = row_nxt;
  assign mul_col = col_nxt;
  always_comb begin
    idx_nxt = idx_r;
    if (cursor_upd) begin
      idx_nxt = IDX_W'(mul_row) * IDX_W'(SCREEN_COLUMNS) + IDX_W'(mul_col);
    end
  end

  // State, cursors and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      sweep_r <= '0;
      row_r   <= '0;
      col_r   <= '0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
    out_pix_r <= out_pix_nxt;
    res_r     <= res_nxt;
  end

  // Pixel store.
  cfp_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (PIXEL_COUNT)
  ) u_pixel_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Output beat: pixel reads take the RAM's registered read data.
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - WORD_W - 2){1'b0}},
                       res_r.refresh_request,
                       res_r.status,
                       (out_pix_r ? ram_rdata : res_r.rdata)};

  // The input side stays closed for the whole sweep.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input accepted during clear sweep");

  // An accepted clear write starts a sweep.
  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd == CMD_WRITE && addr == ADDR_CLEAR)
      |=> (state_r == ST_CLEAR && sweep_r == '0))
    else $error("clear write did not start a sweep");

  // Cursors stay on screen and the cached index follows them.
  a_cursor_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (WORD_W'(row_r) < WORD_W'(SCREEN_ROWS)) && (WORD_W'(col_r) < WORD_W'(SCREEN_COLUMNS))
      && (idx_r == IDX_W'(IDX_W'(row_r) * IDX_W'(SCREEN_COLUMNS) + IDX_W'(col_r))))
    else $error("cursor registers and pixel index disagree");

  // A pending result is never dropped while the receiver stalls.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> (out_v_r && $stable(res_r) && $stable(out_pix_r)))
    else $error("stalled result changed");

endmodule
